// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; the including module must have clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/cop_pkg.sv -----
// shared types, constants and helper functions of the owner predictor
// no dependencies
package cop_pkg;

  localparam int NodeW     = 4;
  localparam int NodeCount = 16;
  localparam int MaskW     = 16;
  localparam int PcW       = 6;
  localparam int PcEntries = 1 << PcW;
  localparam int CntW      = 2;
  localparam int MissW     = 4;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [MissW-1:0] miss_t;
  typedef logic [MaskW-1:0] mask_t;

  localparam cnt_t  CntMax     = cnt_t'(3);
  localparam cnt_t  CntInit    = cnt_t'(1);
  localparam miss_t MissMax    = miss_t'(15);
  localparam cnt_t  ThreshInit = cnt_t'(2);

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  typedef struct packed {
    logic clear;
    logic read;
    logic capture;
    logic write;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_predict;
  } dp_sts_t;

  function automatic cnt_t cnt_up(cnt_t c);
    return (c < CntMax) ? cnt_t'(c + cnt_t'(1)) : c;
  endfunction

  function automatic cnt_t cnt_dn(cnt_t c);
    return (c != '0) ? cnt_t'(c - cnt_t'(1)) : c;
  endfunction

  function automatic mask_t node_bit(node_t n);
    mask_t m;
    m = '0;
    if (int'(n) < NodeCount) begin
      m = mask_t'(1) << n;
    end
    return m;
  endfunction

endpackage

// ----- rtl/coherence_owner_predictor.sv -----
// top level of the owner predictor: controller plus datapath
// depends on cop_pkg, cop_ctrl, cop_dpath and assert_macros.svh
//
//  channel   handshake             word
//  input     in_valid/in_ready     opcode, pc_index, local_node, owner_is_l2, owner_node
//  output    out_valid/out_ready   l1_target_mask, transfer_predicted
//  config    cfg_wr_en             cfg_wr_data (confidence threshold)
//
// each word goes through a table read, then a write-back or an output load
// a predict waits in the lookup cycle while the output register is still full
// after reset a clear pass over all TABLE_ENTRIES entries runs before in_ready rises
// config writes are taken at any time, including during the clear pass
`include "assert_macros.svh"

module coherence_owner_predictor import cop_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int SLOTS         = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           opcode,
  input  logic [PcW-1:0] pc_index,
  input  node_t          local_node,
  input  logic           owner_is_l2,
  input  node_t          owner_node,
  output logic           out_valid,
  input  logic           out_ready,
  output mask_t          l1_target_mask,
  output logic           transfer_predicted,
  input  logic           cfg_wr_en,
  input  cnt_t           cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  cop_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cop_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SLOTS         (SLOTS)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .opcode             (opcode),
    .pc_index           (pc_index),
    .local_node         (local_node),
    .owner_is_l2        (owner_is_l2),
    .owner_node         (owner_node),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .l1_target_mask     (l1_target_mask),
    .transfer_predicted (transfer_predicted)
  );

  `ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "input taken while busy")
  `ASSERT_IMPL(a_out_free, cmd.out_load, !out_valid || out_ready, "output register overrun")
  `ASSERT_IMPL(a_wr_update, cmd.write, !sts.is_predict && !cmd.clear, "bad table write")

endmodule

// ----- rtl/cop_ctrl.sv -----
// sequencing of the owner predictor: clear pass, lookup, write-back, output valid
// depends on cop_pkg
module cop_ctrl import cop_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.read    = 1'b1;
          cmd.capture = 1'b1;
          state_next  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!sts.is_predict) begin
          cmd.write  = 1'b1;
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/cop_dpath.sv -----
// predictor table memory, entry update logic, mask build and output register
// depends on cop_pkg
module cop_dpath import cop_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int SLOTS         = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        opcode,
  input  logic [PcW-1:0] pc_index,
  input  node_t       local_node,
  input  logic        owner_is_l2,
  input  node_t       owner_node,
  input  logic        cfg_wr_en,
  input  cnt_t        cfg_wr_data,
  output mask_t       l1_target_mask,
  output logic        transfer_predicted
);

  localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef struct packed {
    cnt_t                    tc;
    cnt_t                    pcf;
    node_t                   ptr;
    cnt_t                    gc;
    logic  [SLOTS-1:0]       sv;
    logic  [SLOTS-1:0][NodeW-1:0] so;
    logic  [SLOTS-1:0][MissW-1:0] sm;
  } entry_t;

  localparam entry_t EntryInit = '{tc: CntInit, pcf: CntInit, ptr: '0, gc: CntInit,
                                   sv: '0, so: '0, sm: '0};

  entry_t            mem [TABLE_ENTRIES];
  entry_t            rd;
  entry_t            upd;
  logic [IdxW-1:0]   idx_map [PcEntries];
  logic [IdxW-1:0]   clr_cnt;
  logic [IdxW-1:0]   idx_q;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;
  logic              mem_we;
  logic              op_q;
  logic              l2_q;
  node_t             own_q;
  node_t             loc_q;
  cnt_t              thresh;
  mask_t             mask;
  logic              xfer;

  for (genvar i = 0; i < PcEntries; i++) begin : g_idx
    assign idx_map[i] = IdxW'(i % TABLE_ENTRIES);
  end

  assign sts.clear_last = (clr_cnt == LastIdx);
  assign sts.is_predict = (op_q == OP_PREDICT);

  // config and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh  <= ThreshInit;
      clr_cnt <= '0;
    end else begin
      if (cfg_wr_en) begin
        thresh <= cfg_wr_data;
      end
      if (cmd.clear && !sts.clear_last) begin
        clr_cnt <= clr_cnt + IdxW'(1);
      end
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      l2_q  <= owner_is_l2;
      own_q <= owner_node;
      loc_q <= local_node;
      idx_q <= idx_map[pc_index];
    end
  end

  // table memory
  assign mem_we  = cmd.clear || cmd.write;
  assign wr_addr = cmd.clear ? clr_cnt : idx_q;
  assign wr_data = cmd.clear ? EntryInit : upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd <= mem[idx_map[pc_index]];
    end
  end

  // training
  always_comb begin
    logic [SLOTS-1:0] match;
    logic             hit;
    logic [SlotW-1:0] v;
    upd   = rd;
    match = '0;
    v     = '0;
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = rd.sv[s] && (rd.so[s] == own_q);
    end
    hit = |match;
    if (l2_q) begin
      upd.tc = cnt_dn(rd.tc);
    end else begin
      upd.tc = cnt_up(rd.tc);
      if (own_q == rd.ptr) begin
        upd.pcf = cnt_up(rd.pcf);
      end else begin
        upd.pcf = cnt_dn(rd.pcf);
        if (upd.pcf < thresh) begin
          upd.ptr = own_q;
        end
      end
      if (hit) begin
        upd.gc = cnt_up(rd.gc);
        for (int s = 0; s < SLOTS; s++) begin
          if (rd.sv[s]) begin
            if (match[s]) begin
              upd.sm[s] = '0;
            end else if (rd.sm[s] < MissMax) begin
              upd.sm[s] = rd.sm[s] + miss_t'(1);
            end
          end
        end
      end else begin
        upd.gc = cnt_dn(rd.gc);
        // first invalid slot, else first slot with most misses
        for (int s = 1; s < SLOTS; s++) begin
          if (rd.sv[v] && (!rd.sv[s] || (rd.sm[s] > rd.sm[v]))) begin
            v = SlotW'(s);
          end
        end
        upd.so[v] = own_q;
        upd.sm[v] = '0;
        upd.sv[v] = 1'b1;
      end
    end
  end

  // prediction
  always_comb begin
    mask = node_bit(loc_q);
    xfer = (rd.tc >= thresh);
    if (xfer) begin
      if (rd.pcf >= thresh) begin
        mask = mask | node_bit(rd.ptr);
      end
      if (rd.gc >= thresh) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (rd.sv[s] && (rd.so[s] != rd.ptr)) begin
            mask = mask | node_bit(rd.so[s]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      l1_target_mask     <= mask;
      transfer_predicted <= xfer;
    end
  end

endmodule

// ----- dv/tb_coherence_owner_predictor.sv -----
// testbench for coherence_owner_predictor: directed and random predict/update words
// with a scoreboard that models the owner table, checked against every output word
// depends on cop_pkg and the rtl of coherence_owner_predictor
module tb_coherence_owner_predictor;
  import cop_pkg::*;

  localparam int SlotCount     = 4;
  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 120;
  localparam int SettleCycles  = 4;
  localparam int PhaseWords    = 275;

  typedef struct packed {
    mask_t mask;
    logic  xfer;
  } snoop_guess_t;

  class owner_table_scoreboard;
    cnt_t         xfer_conf [PcEntries];
    cnt_t         ptr_conf [PcEntries];
    cnt_t         group_conf [PcEntries];
    node_t        owner_ptr [PcEntries];
    node_t        slot_node [PcEntries][SlotCount];
    logic         slot_ok [PcEntries][SlotCount];
    miss_t        slot_miss [PcEntries][SlotCount];
    cnt_t         threshold;
    snoop_guess_t snoop_guesses[$];
    int           errors;

    function new();
      for (int e = 0; e < PcEntries; e++) begin
        xfer_conf[e]  = 2'd1;
        ptr_conf[e]   = 2'd1;
        group_conf[e] = 2'd1;
        owner_ptr[e]  = '0;
        for (int s = 0; s < SlotCount; s++) begin
          slot_node[e][s] = '0;
          slot_ok[e][s]   = 1'b0;
          slot_miss[e][s] = '0;
        end
      end
      threshold = 2'd2;
      errors    = 0;
    endfunction

    function cnt_t sat_inc(cnt_t c);
      return (c == 2'd3) ? c : c + 2'd1;
    endfunction

    function cnt_t sat_dec(cnt_t c);
      return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    function int pending();
      return snoop_guesses.size();
    endfunction

    // advance the table by one accepted input word
    function void apply_word(op_t op, logic [PcW-1:0] e, node_t loc, logic l2, node_t own);
      snoop_guess_t g;
      logic         hit;
      int           v;
      if (op == OP_PREDICT) begin
        g.mask = mask_t'(1) << loc;
        g.xfer = xfer_conf[e] >= threshold;
        if (g.xfer) begin
          if (ptr_conf[e] >= threshold) g.mask |= mask_t'(1) << owner_ptr[e];
          if (group_conf[e] >= threshold) begin
            for (int s = 0; s < SlotCount; s++)
              if (slot_ok[e][s] && slot_node[e][s] != owner_ptr[e])
                g.mask |= mask_t'(1) << slot_node[e][s];
          end
        end
        snoop_guesses.push_back(g);
        return;
      end
      if (l2) begin
        xfer_conf[e] = sat_dec(xfer_conf[e]);
        return;
      end
      xfer_conf[e] = sat_inc(xfer_conf[e]);
      if (own == owner_ptr[e]) begin
        ptr_conf[e] = sat_inc(ptr_conf[e]);
      end else begin
        ptr_conf[e] = sat_dec(ptr_conf[e]);
        if (ptr_conf[e] < threshold) owner_ptr[e] = own;
      end
      hit = 1'b0;
      for (int s = 0; s < SlotCount; s++)
        if (slot_ok[e][s] && slot_node[e][s] == own) hit = 1'b1;
      if (hit) begin
        group_conf[e] = sat_inc(group_conf[e]);
        for (int s = 0; s < SlotCount; s++) begin
          if (slot_ok[e][s]) begin
            if (slot_node[e][s] == own) slot_miss[e][s] = '0;
            else if (slot_miss[e][s] != 4'd15) slot_miss[e][s] = slot_miss[e][s] + 4'd1;
          end
        end
      end else begin
        group_conf[e] = sat_dec(group_conf[e]);
        // first free slot, else first slot with the most misses
        v = 0;
        for (int s = 1; s < SlotCount; s++)
          if (slot_ok[e][v] && (!slot_ok[e][s] || slot_miss[e][s] > slot_miss[e][v])) v = s;
        slot_node[e][v] = own;
        slot_miss[e][v] = '0;
        slot_ok[e][v]   = 1'b1;
      end
    endfunction

    function void check_snoop(mask_t m, logic x);
      snoop_guess_t g;
      if (snoop_guesses.size() == 0) begin
        $error("unexpected output word: l1_target_mask %h transfer_predicted %b", m, x);
        errors++;
        return;
      end
      g = snoop_guesses.pop_front();
      if (m !== g.mask) begin
        $error("l1_target_mask expected %h actual %h", g.mask, m);
        errors++;
      end
      if (x !== g.xfer) begin
        $error("transfer_predicted expected %b actual %b", g.xfer, x);
        errors++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic           opcode = 1'b0;
  logic [PcW-1:0] pc_index = '0;
  node_t          local_node = '0;
  logic           owner_is_l2 = 1'b0;
  node_t          owner_node = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  mask_t          l1_target_mask;
  logic           transfer_predicted;
  logic           cfg_wr_en = 1'b0;
  cnt_t           cfg_wr_data = '0;

  owner_table_scoreboard sb = new();

  int tx_calm = 0;
  int rx_calm = 0;
  int ready_wait = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int idle_cycles = 0;

  coherence_owner_predictor i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .opcode             (opcode),
    .pc_index           (pc_index),
    .local_node         (local_node),
    .owner_is_l2        (owner_is_l2),
    .owner_node         (owner_node),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .l1_target_mask     (l1_target_mask),
    .transfer_predicted (transfer_predicted),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle cycles before the next word, with occasional back-to-back runs
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  always @(posedge clk) begin : rx_side
    int g;
    if (rst) begin
      out_ready <= 1'b0;
      ready_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_snoop(l1_target_mask, transfer_predicted);
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= LongHold;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        g = draw_gap(rx_calm);
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          ready_wait <= g - 1;
        end
      end else if (!out_ready) begin
        if (ready_wait == 0) out_ready <= 1'b1;
        else ready_wait <= ready_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid is only lowered when a gap follows, so it never toggles within one step
  task automatic send_word(op_t op, logic [PcW-1:0] pc, node_t loc, logic l2, node_t own);
    int g;
    g = draw_gap(tx_calm);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    pc_index    <= pc;
    local_node  <= loc;
    owner_is_l2 <= l2;
    owner_node  <= own;
    do @(posedge clk); while (!in_ready);
    sb.apply_word(op, pc, loc, l2, own);
  endtask

  // wait for all outstanding words, then let trailing updates finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_threshold(cnt_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.threshold = v;
  endtask

  // a few hot entries, each trained by a small home set of owners plus strays
  task automatic run_phase(int words);
    logic [PcW-1:0] hot [4];
    node_t          home [4][3];
    int             h;
    op_t            op;
    node_t          own;
    for (int i = 0; i < 4; i++) begin
      hot[i] = PcW'($urandom_range(0, PcEntries - 1));
      for (int j = 0; j < 3; j++) home[i][j] = node_t'($urandom_range(0, NodeCount - 1));
    end
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(op_t'($urandom_range(0, 1)), PcW'($urandom_range(0, PcEntries - 1)),
                  node_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  node_t'($urandom_range(0, 15)));
      end else begin
        h   = $urandom_range(0, 3);
        op  = ($urandom_range(0, 4) < 3) ? OP_UPDATE : OP_PREDICT;
        own = ($urandom_range(0, 3) != 0) ? home[h][$urandom_range(0, 2)]
                                          : node_t'($urandom_range(0, 15));
        send_word(op, hot[h], node_t'($urandom_range(0, 15)), ($urandom_range(0, 7) == 0), own);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset state: nothing trusted yet, ignored update fields set on a predict
    send_word(OP_PREDICT, 6'd0, 4'd0, 1'b1, 4'd15);
    send_word(OP_PREDICT, 6'd63, 4'd15, 1'b0, 4'd0);
    // train the top entry, fill every slot, force a replacement
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd15);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd15);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd15);
    send_word(OP_PREDICT, 6'd63, 4'd0, 1'b0, 4'd0);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd0);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd5);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd9);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd12);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd0);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd0);
    send_word(OP_PREDICT, 6'd63, 4'd7, 1'b0, 4'd0);
    // l2 owners drain the transfer counter down to zero, where it saturates
    for (int i = 0; i < 4; i++) send_word(OP_UPDATE, 6'd63, 4'd15, 1'b1, 4'd15);
    send_word(OP_PREDICT, 6'd63, 4'd15, 1'b0, 4'd0);
    settle();

    // threshold zero trusts every counter
    write_threshold(2'd0);
    send_word(OP_PREDICT, 6'd1, 4'd8, 1'b0, 4'd0);
    send_word(OP_PREDICT, 6'd63, 4'd2, 1'b0, 4'd0);
    settle();
    write_threshold(2'd3);
    send_word(OP_PREDICT, 6'd63, 4'd4, 1'b0, 4'd0);
    send_word(OP_UPDATE, 6'd63, 4'd0, 1'b0, 4'd3);
    send_word(OP_PREDICT, 6'd63, 4'd4, 1'b0, 4'd0);
    settle();

    write_threshold(2'd0);
    run_phase(PhaseWords);
    settle();
    write_threshold(2'd3);
    // output held off while words keep coming, so the input backs up
    hold_req <= hold_req + 1;
    run_phase(PhaseWords);
    settle();
    write_threshold(2'd1);
    run_phase(PhaseWords);
    settle();
    write_threshold(2'd2);
    run_phase(PhaseWords);
    settle();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cop_pkg.sv
rtl/cop_ctrl.sv
rtl/cop_dpath.sv
rtl/coherence_owner_predictor.sv
dv/tb_coherence_owner_predictor.sv
